// ===== hdl/lmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lmc_pkg: shared types and constants of the LED matrix chain controller
// Command codes, driver register numbers, fixed field widths and the command
// record that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package lmc_pkg;

   // Field widths
   localparam int FUNC_W    = 4;
   localparam int DISP_W    = 3;
   localparam int COL_W     = 3;
   localparam int ROW_W     = 3;
   localparam int DATA_W    = 8;
   localparam int REGADDR_W = 4;
   localparam int POS_W     = 8;

   // Defaults
   localparam int CHAIN_LENGTH_DEFAULT = 4;
   // Command queue depth, a power of two
   localparam int QUEUE_DEPTH = 2;

   // Command codes
   localparam logic [FUNC_W-1:0] FUNC_INIT       = 4'd0;
   localparam logic [FUNC_W-1:0] FUNC_PIXEL      = 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_COLUMN     = 4'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR_ONE  = 4'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR_ALL  = 4'd4;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH_ONE  = 4'd5;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH_ALL  = 4'd6;
   localparam logic [FUNC_W-1:0] FUNC_INTENSITY  = 4'd7;
   localparam logic [FUNC_W-1:0] FUNC_SHUTDOWN   = 4'd8;

   // Driver register numbers
   localparam logic [REGADDR_W-1:0] REG_NOOP       = 4'd0;
   localparam logic [REGADDR_W-1:0] REG_DIGIT_BASE = 4'd1;
   localparam logic [REGADDR_W-1:0] REG_DECODE     = 4'd9;
   localparam logic [REGADDR_W-1:0] REG_BRIGHTNESS = 4'd10;
   localparam logic [REGADDR_W-1:0] REG_SCANLIMIT  = 4'd11;
   localparam logic [REGADDR_W-1:0] REG_SHUTDOWN   = 4'd12;

   // Register values sent at start-up and shutdown
   localparam logic [DATA_W-1:0] SHUTDOWN_NORMAL = 8'h01;
   localparam logic [DATA_W-1:0] SHUTDOWN_OFF    = 8'h00;
   localparam logic [DATA_W-1:0] SCAN_ALL_DIGITS = 8'h07;
   localparam logic [DATA_W-1:0] INTENSITY_MIN   = 8'h00;
   localparam logic [DATA_W-1:0] DECODE_NONE     = 8'h00;
   localparam logic [DATA_W-1:0] NOOP_DATA       = 8'h00;

   // Classified command handed to the back end
   typedef struct packed {
      logic [FUNC_W-1:0] op;
      logic [DISP_W-1:0] disp;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [DATA_W-1:0] data;
      logic              pix_on;
      logic              flush;
   } cmd_type;

endpackage

// ===== hdl/lmc_front.sv =====
// ----------------------------------------------------------------------------
// lmc_front: command intake and classification
// Accepts items, drops those that neither change the frame store nor emit
// words, and pushes the rest with the auto flush decision into the queue.
// ----------------------------------------------------------------------------
module lmc_front #(
   parameter int CHAIN_LENGTH = lmc_pkg::CHAIN_LENGTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lmc_pkg::FUNC_W-1:0]        req_func,
   input  logic [lmc_pkg::DISP_W-1:0]        req_display,
   input  logic [lmc_pkg::POS_W-1:0]         req_pixel_position,
   input  logic [lmc_pkg::COL_W-1:0]         req_column,
   input  logic [lmc_pkg::DATA_W-1:0]        req_data_value,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,
   output logic                              push_valid,
   input  logic                              push_ready,
   output lmc_pkg::cmd_type                  push_cmd
);

   logic auto_flush_ff;
   logic auto_flush_in;
   logic accept;
   logic disp_ok;
   logic pos_ok;
   logic keep;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // Range checks on display and pixel position
   assign disp_ok = {1'b0, req_display} < 4'(CHAIN_LENGTH);
   assign pos_ok  = !req_pixel_position[7] && !req_pixel_position[3];

   // Keep only items with an effect
   always_comb begin
      unique case (req_func)
         lmc_pkg::FUNC_INIT,
         lmc_pkg::FUNC_CLEAR_ALL,
         lmc_pkg::FUNC_FLUSH_ALL,
         lmc_pkg::FUNC_INTENSITY,
         lmc_pkg::FUNC_SHUTDOWN:  keep = 1'b1;
         lmc_pkg::FUNC_PIXEL:     keep = disp_ok && pos_ok;
         lmc_pkg::FUNC_COLUMN,
         lmc_pkg::FUNC_CLEAR_ONE,
         lmc_pkg::FUNC_FLUSH_ONE: keep = disp_ok;
         default:                 keep = 1'b0;
      endcase
   end

   // Build the command record
   always_comb begin
      push_cmd.op     = req_func;
      push_cmd.disp   = req_display;
      push_cmd.col    = (req_func == lmc_pkg::FUNC_PIXEL) ? req_pixel_position[6:4]
                                                          : req_column;
      push_cmd.row    = req_pixel_position[2:0];
      push_cmd.data   = req_data_value;
      push_cmd.pix_on = |req_data_value;
      push_cmd.flush  = auto_flush_ff;
   end

   assign push_valid = accept && keep;

   // Auto flush register: written by the port, cleared by init
   always_comb begin
      auto_flush_in = auto_flush_ff;
      if (csr_wr_en) begin
         auto_flush_in = csr_wr_data;
      end else if (accept && req_func == lmc_pkg::FUNC_INIT) begin
         auto_flush_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_flush_ff <= 1'b0;
      end else begin
         auto_flush_ff <= auto_flush_in;
      end
   end

endmodule

// ===== hdl/lmc_queue.sv =====
// ----------------------------------------------------------------------------
// lmc_queue: short command queue between front and back end
// Holds classified commands so intake and word emission stall independently.
// ----------------------------------------------------------------------------
module lmc_queue #(
   parameter int DEPTH = lmc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  lmc_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop,
   output lmc_pkg::cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = PTR_W + 1;

   lmc_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/lmc_back.sv =====
// ----------------------------------------------------------------------------
// lmc_back: frame store and register word sequencer
// Carries out queued commands on the frame store memory and emits the
// register words, one chip-select frame of chain-length words at a time.
// ----------------------------------------------------------------------------
module lmc_back #(
   parameter int CHAIN_LENGTH = lmc_pkg::CHAIN_LENGTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  lmc_pkg::cmd_type              q_cmd,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lmc_pkg::REGADDR_W-1:0] rsp_reg_address,
   output logic [lmc_pkg::DATA_W-1:0]    rsp_reg_data,
   output logic                          rsp_frame_end,
   output logic                          rsp_last
);

   localparam int DEPTH  = CHAIN_LENGTH * 8;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [lmc_pkg::DISP_W-1:0] LAST_DISP = lmc_pkg::DISP_W'(CHAIN_LENGTH - 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_EXEC    = 3'd1;
   localparam logic [2:0] ST_PIX_WR  = 3'd2;
   localparam logic [2:0] ST_FL_RD   = 3'd3;
   localparam logic [2:0] ST_FL_EMIT = 3'd4;
   localparam logic [2:0] ST_BCAST   = 3'd5;

   localparam logic [1:0] STEP_LAST = 2'd3;

   // State and counters
   logic [2:0]                      state_ff, state_in;
   lmc_pkg::cmd_type                cmd_ff, cmd_in;
   logic [lmc_pkg::DISP_W-1:0]      k_ff, k_in;
   logic [lmc_pkg::COL_W-1:0]       col_ff, col_in;
   logic [1:0]                      step_ff, step_in;

   // Frame store
   logic [lmc_pkg::DATA_W-1:0]      mem [DEPTH];
   logic [DEPTH-1:0]                valid_ff;
   logic [lmc_pkg::DATA_W-1:0]      rd_data_ff;
   logic                            rd_valid_ff;

   // Output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lmc_pkg::REGADDR_W-1:0]   rsp_addr_ff;
   logic [lmc_pkg::DATA_W-1:0]      rsp_data_ff;
   logic                            rsp_fend_ff;
   logic                            rsp_last_ff;

   // Datapath controls
   logic                            slot_free;
   logic                            is_all;
   logic                            k_last;
   logic                            col_last;
   logic                            bcast_final;
   logic [lmc_pkg::DISP_W-1:0]      k_nx;
   logic [lmc_pkg::COL_W-1:0]       col_nx;
   logic [lmc_pkg::DATA_W-1:0]      word_byte;
   logic [lmc_pkg::DATA_W-1:0]      pix_mask;
   logic [lmc_pkg::DATA_W-1:0]      pix_byte;
   logic [lmc_pkg::DISP_W-1:0]      rd_disp;
   logic [lmc_pkg::COL_W-1:0]       rd_col;
   logic [ADDR_W-1:0]               rd_addr;
   logic [ADDR_W-1:0]               wr_addr;
   logic                            mem_re;
   logic                            mem_we;
   logic [lmc_pkg::DATA_W-1:0]      wr_data;
   logic                            set_valid;
   logic                            clr_row;
   logic                            clr_all;
   logic                            emit;
   logic [lmc_pkg::REGADDR_W-1:0]   emit_addr;
   logic [lmc_pkg::DATA_W-1:0]      emit_data;
   logic                            emit_fend;
   logic                            emit_last;
   logic [lmc_pkg::REGADDR_W-1:0]   bc_addr;
   logic [lmc_pkg::DATA_W-1:0]      bc_data;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_all    = (cmd_ff.op == lmc_pkg::FUNC_CLEAR_ALL) ||
                      (cmd_ff.op == lmc_pkg::FUNC_FLUSH_ALL);
   assign k_last    = k_ff == '0;
   assign col_last  = col_ff == '0;
   assign k_nx      = k_last ? LAST_DISP : k_ff - 1'b1;
   assign col_nx    = k_last ? col_ff - 1'b1 : col_ff;

   // Unwritten entries read as blank
   assign word_byte = rd_valid_ff ? rd_data_ff : '0;
   assign pix_mask  = lmc_pkg::DATA_W'(1) << cmd_ff.row;
   assign pix_byte  = cmd_ff.pix_on ? (word_byte | pix_mask) : (word_byte & ~pix_mask);

   assign wr_addr = ADDR_W'({cmd_ff.disp, cmd_ff.col});
   assign rd_addr = ADDR_W'({rd_disp, rd_col});

   // Broadcast word for the current frame
   assign bcast_final = (cmd_ff.op != lmc_pkg::FUNC_INIT) || (step_ff == STEP_LAST);
   always_comb begin
      bc_addr = lmc_pkg::REG_SHUTDOWN;
      bc_data = lmc_pkg::SHUTDOWN_OFF;
      if (cmd_ff.op == lmc_pkg::FUNC_INIT) begin
         unique case (step_ff)
            2'd0: begin
               bc_addr = lmc_pkg::REG_SHUTDOWN;
               bc_data = lmc_pkg::SHUTDOWN_NORMAL;
            end
            2'd1: begin
               bc_addr = lmc_pkg::REG_SCANLIMIT;
               bc_data = lmc_pkg::SCAN_ALL_DIGITS;
            end
            2'd2: begin
               bc_addr = lmc_pkg::REG_BRIGHTNESS;
               bc_data = lmc_pkg::INTENSITY_MIN;
            end
            default: begin
               bc_addr = lmc_pkg::REG_DECODE;
               bc_data = lmc_pkg::DECODE_NONE;
            end
         endcase
      end else if (cmd_ff.op == lmc_pkg::FUNC_INTENSITY) begin
         bc_addr = lmc_pkg::REG_BRIGHTNESS;
         bc_data = cmd_ff.data;
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      k_in      = k_ff;
      col_in    = col_ff;
      step_in   = step_ff;
      q_pop     = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      wr_data   = cmd_ff.data;
      rd_disp   = cmd_ff.disp;
      rd_col    = cmd_ff.col;
      set_valid = 1'b0;
      clr_row   = 1'b0;
      clr_all   = 1'b0;
      emit      = 1'b0;
      emit_addr = lmc_pkg::REG_NOOP;
      emit_data = lmc_pkg::NOOP_DATA;
      emit_fend = 1'b0;
      emit_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // Start every frame sequence at the furthest display, top column
            k_in    = LAST_DISP;
            col_in  = '1;
            step_in = '0;
            unique case (cmd_ff.op)
               lmc_pkg::FUNC_PIXEL: begin
                  mem_re   = 1'b1;
                  state_in = ST_PIX_WR;
               end
               lmc_pkg::FUNC_COLUMN: begin
                  mem_we    = 1'b1;
                  set_valid = 1'b1;
                  state_in  = cmd_ff.flush ? ST_FL_RD : ST_IDLE;
               end
               lmc_pkg::FUNC_CLEAR_ONE: begin
                  clr_row  = 1'b1;
                  state_in = cmd_ff.flush ? ST_FL_RD : ST_IDLE;
               end
               lmc_pkg::FUNC_CLEAR_ALL: begin
                  clr_all  = 1'b1;
                  state_in = cmd_ff.flush ? ST_FL_RD : ST_IDLE;
               end
               lmc_pkg::FUNC_FLUSH_ONE,
               lmc_pkg::FUNC_FLUSH_ALL: state_in = ST_FL_RD;
               lmc_pkg::FUNC_INIT,
               lmc_pkg::FUNC_INTENSITY,
               lmc_pkg::FUNC_SHUTDOWN:  state_in = ST_BCAST;
               default:                 state_in = ST_IDLE;
            endcase
         end
         ST_PIX_WR: begin
            // Read-modify-write of one column byte
            mem_we    = 1'b1;
            wr_data   = pix_byte;
            set_valid = 1'b1;
            state_in  = cmd_ff.flush ? ST_FL_RD : ST_IDLE;
         end
         ST_FL_RD: begin
            mem_re   = 1'b1;
            rd_disp  = is_all ? k_ff : cmd_ff.disp;
            rd_col   = col_ff;
            state_in = ST_FL_EMIT;
         end
         ST_FL_EMIT: begin
            if (slot_free) begin
               emit = 1'b1;
               if (is_all || k_ff == cmd_ff.disp) begin
                  emit_addr = lmc_pkg::REGADDR_W'(col_ff) + lmc_pkg::REG_DIGIT_BASE;
                  emit_data = word_byte;
               end
               emit_fend = k_last;
               emit_last = k_last && col_last;
               k_in      = k_nx;
               col_in    = col_nx;
               // Fetch the next word while this one goes out
               mem_re    = 1'b1;
               rd_disp   = is_all ? k_nx : cmd_ff.disp;
               rd_col    = col_nx;
               if (k_last && col_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BCAST: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_addr = bc_addr;
               emit_data = bc_data;
               emit_fend = k_last;
               emit_last = k_last && bcast_final;
               k_in      = k_nx;
               if (k_last) begin
                  if (bcast_final) begin
                     state_in = ST_IDLE;
                  end else begin
                     step_in = step_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      k_ff    <= k_in;
      col_ff  <= col_in;
      step_ff <= step_in;
   end

   // Entry valid bits: a cleared entry reads as blank
   always_ff @(posedge clock) begin
      if (reset || clr_all) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            if (clr_row && lmc_pkg::DISP_W'(i >> 3) == cmd_ff.disp) begin
               valid_ff[i] <= 1'b0;
            end
         end
         if (set_valid) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Frame store memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_addr_ff <= emit_addr;
         rsp_data_ff <= emit_data;
         rsp_fend_ff <= emit_fend;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reg_address = rsp_addr_ff;
   assign rsp_reg_data    = rsp_data_ff;
   assign rsp_frame_end   = rsp_fend_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== hdl/led_matrix_chain_frame_controller.sv =====
// ----------------------------------------------------------------------------
// led_matrix_chain_frame_controller: daisy-chained 8x8 LED matrix driver
// Keeps an 8-byte column frame per display and turns commands into register
// words grouped in chip-select frames, furthest display first.
// ----------------------------------------------------------------------------
// Commands enter a two-entry queue and are carried out one at a time by a
// sequencer that emits one register word per cycle while the result side
// takes them. A broadcast command (intensity, shutdown) gives CHAIN_LENGTH
// words and init gives 4*CHAIN_LENGTH; a flush gives 8*CHAIN_LENGTH words
// (32 for a chain of four) after the EXEC and FL_RD setup states; a pixel
// draw adds the PIX_WR state for the read-modify-write of its column byte,
// and each command leaves the queue in the IDLE state. The word rate is set
// by the single read port of the frame store and the single output
// register. Items that change nothing and emit nothing are taken, when the
// queue has room, and dropped. The frame store needs no clearing pass:
// per-entry valid bits let reset and clear commands take effect without it.
module led_matrix_chain_frame_controller #(
   parameter int CHAIN_LENGTH = lmc_pkg::CHAIN_LENGTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lmc_pkg::FUNC_W-1:0]    req_func,
   input  logic [lmc_pkg::DISP_W-1:0]    req_display,
   input  logic [lmc_pkg::POS_W-1:0]     req_pixel_position,
   input  logic [lmc_pkg::COL_W-1:0]     req_column,
   input  logic [lmc_pkg::DATA_W-1:0]    req_data_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lmc_pkg::REGADDR_W-1:0] rsp_reg_address,
   output logic [lmc_pkg::DATA_W-1:0]    rsp_reg_data,
   output logic                          rsp_frame_end,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data
);

   logic             push_valid;
   logic             push_ready;
   lmc_pkg::cmd_type push_cmd;
   logic             q_valid;
   logic             q_pop;
   lmc_pkg::cmd_type q_cmd;

   // Intake and classification
   lmc_front #(
      .CHAIN_LENGTH(CHAIN_LENGTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_display        (req_display),
      .req_pixel_position (req_pixel_position),
      .req_column         (req_column),
      .req_data_value     (req_data_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_cmd           (push_cmd)
   );

   // Command queue
   lmc_queue #(
      .DEPTH(lmc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_cmd    (q_cmd)
   );

   // Frame store and word sequencer
   lmc_back #(
      .CHAIN_LENGTH(CHAIN_LENGTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reg_address (rsp_reg_address),
      .rsp_reg_data    (rsp_reg_data),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== hdl/lmc_checker.sv =====
// ----------------------------------------------------------------------------
// lmc_checker: port-level checks for the LED matrix chain controller
// Watches the result channel for word and frame structure rules.
// ----------------------------------------------------------------------------
module lmc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lmc_pkg::REGADDR_W-1:0] rsp_reg_address,
   input logic [lmc_pkg::DATA_W-1:0]    rsp_reg_data,
   input logic                          rsp_frame_end,
   input logic                          rsp_last
);

   // Hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reg_address) &&
      $stable(rsp_reg_data) && $stable(rsp_frame_end) && $stable(rsp_last))
      else $error("stalled result word changed");

   // A command always ends on a frame boundary
   a_last_on_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_frame_end)
      else $error("last word not at end of a frame");

   // No-op words carry zero data
   a_noop_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_address == lmc_pkg::REG_NOOP |-> rsp_reg_data == '0)
      else $error("no-op word with non-zero data");

   // Only defined driver registers are addressed
   a_reg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reg_address <= lmc_pkg::REG_SHUTDOWN)
      else $error("register address out of range");

endmodule

bind led_matrix_chain_frame_controller lmc_checker u_lmc_checker (.*);
